// ===== src/spu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spu_pkg;

  localparam int SEPTET_BITS = 7;
  localparam int BYTE_BITS   = 8;
  // Pending bits between septets never exceed BYTE_BITS - 1.
  localparam int COUNT_W     = $clog2(BYTE_BITS);

  typedef logic [SEPTET_BITS-1:0] septet_t;
  typedef logic [BYTE_BITS-1:0]   byte_t;
  typedef logic [COUNT_W-1:0]     count_t;

  typedef struct packed {
    septet_t septet;
    logic    last_septet;
  } in_item_t;

  typedef struct packed {
    byte_t  data_byte;
    logic   byte_valid;
    logic   frame_end;
    count_t leftover_bits;
  } result_t;

endpackage

`default_nettype wire

// ===== src/spu_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spu_in_stage
  import spu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          held_valid,
  output in_item_t      held_item,
  input  wire logic     take
);

  // The held item stays put until the unpack stage takes it.
  assign in_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== src/spu_unpack.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spu_unpack
  import spu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     held_valid,
  input  wire in_item_t held_item,
  output logic          take,
  output logic          out_valid,
  input  wire logic     out_stall,
  output result_t       result
);

  // Pending bits are right aligned; bits above bit_count are kept at zero.
  septet_t bit_store;
  count_t  bit_count;

  septet_t                      bit_store_next;
  count_t                       bit_count_next;
  logic [2*SEPTET_BITS-1:0]     joined;
  logic [2*SEPTET_BITS-1:0]     shifted;
  count_t                       rest;
  logic                         have_byte;
  result_t                      result_next;
  logic                         out_free;

  assign out_free = !out_valid || !out_stall;
  assign take     = held_valid && out_free;

  always_comb begin
    joined    = {bit_store, held_item.septet};
    have_byte = (bit_count != '0);
    rest      = bit_count - count_t'(1);
    shifted   = joined >> rest;
    if (have_byte) begin
      bit_count_next = rest;
      bit_store_next = held_item.septet & ~(septet_t'('1) << rest);
    end else begin
      bit_count_next = count_t'(SEPTET_BITS);
      bit_store_next = held_item.septet;
    end
    result_next.data_byte     = have_byte ? shifted[BYTE_BITS-1:0] : '0;
    result_next.byte_valid    = have_byte;
    result_next.frame_end     = held_item.last_septet;
    result_next.leftover_bits = held_item.last_septet ? bit_count_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_store <= '0;
      bit_count <= '0;
    end else if (take) begin
      if (held_item.last_septet) begin
        bit_store <= '0;
        bit_count <= '0;
      end else begin
        bit_store <= bit_store_next;
        bit_count <= bit_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= take && (have_byte || held_item.last_septet);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

`ifndef SYNTH
  a_frame_restart : assert property (@(posedge clk) disable iff (rst)
    take && held_item.last_septet |=> bit_count == '0 && bit_store == '0)
    else $error("unpack state not cleared after frame end");

  a_store_clean : assert property (@(posedge clk) disable iff (rst)
    (bit_store >> bit_count) == '0)
    else $error("stale bits above the pending count");

  a_mid_frame_byte : assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.frame_end |-> result.byte_valid && result.leftover_bits == '0)
    else $error("mid-frame result without a byte");

  a_no_byte_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.byte_valid |-> result.data_byte == '0)
    else $error("data_byte not zero on a result without a byte");
`endif

endmodule

`default_nettype wire

// ===== src/septet_stream_to_byte_unpack_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Septet-to-byte unpacker. Seven-bit septets are joined most significant bit
// first into one bit stream and each eight-bit byte is sent as soon as its
// last bit arrives; a frame of n septets gives floor(7n/8) bytes. The septet
// flagged last_septet always gives a result marked frame_end, with byte_valid
// telling whether it carries a byte and leftover_bits counting the dropped
// tail bits. A mid-frame septet that completes no byte gives no result. One
// septet is taken per clock while the output is not stalled; each transfer
// passes an input register, shift-and-append logic and a result register
// before its result is offered.
module septet_stream_to_byte_unpack_top
  import spu_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [6:0]           septet,
  input  wire logic                 last_septet,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                data_byte,
  output logic                      byte_valid,
  output logic                      frame_end,
  output logic [2:0]                leftover_bits
);

  in_item_t in_item;
  in_item_t held_item;
  logic     held_valid;
  logic     take;
  result_t  result;

  assign in_item.septet      = septet;
  assign in_item.last_septet = last_septet;

  spu_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take)
  );

  spu_unpack u_unpack (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  assign data_byte     = result.data_byte;
  assign byte_valid    = result.byte_valid;
  assign frame_end     = result.frame_end;
  assign leftover_bits = result.leftover_bits;

endmodule

`default_nettype wire

// ===== test/tb_septet_stream_to_byte_unpack_top.sv =====
`timescale 1ns / 1ps

module tb_septet_stream_to_byte_unpack_top;
  import spu_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 20;
  localparam int HOLD_LEN    = 300;
  localparam int PHASE_ITEMS = 330;

  class unpack_scoreboard;
    logic [13:0] pend_bits;
    logic [3:0]  pend_count;
    result_t     awaited[$];
    int          errors;

    function new();
      pend_bits  = '0;
      pend_count = '0;
      errors     = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Appends one septet to the bit stream and queues what it completes.
    function void note_septet(septet_t s, logic last);
      int      cnt;
      int      rest;
      int      bits;
      int      byte_val;
      logic    have_byte;
      result_t r;
      cnt       = int'(pend_count[2:0]);
      bits      = int'(pend_bits) & ((1 << cnt) - 1);
      byte_val  = 0;
      have_byte = 1'b0;
      bits      = ((bits << SEPTET_BITS) | int'(s)) & 14'h3fff;
      cnt       = cnt + SEPTET_BITS;
      if (cnt >= BYTE_BITS) begin
        rest      = cnt - BYTE_BITS;
        byte_val  = (bits >> rest) & 8'hff;
        have_byte = 1'b1;
        cnt       = rest;
        bits      = bits & ((1 << cnt) - 1);
      end
      if (last) begin
        r.data_byte     = byte_t'(byte_val);
        r.byte_valid    = have_byte;
        r.frame_end     = 1'b1;
        r.leftover_bits = count_t'(cnt);
        awaited.push_back(r);
        pend_bits  = '0;
        pend_count = '0;
      end else begin
        pend_bits  = 14'(bits);
        pend_count = 4'(cnt);
        if (have_byte) begin
          r.data_byte     = byte_t'(byte_val);
          r.byte_valid    = 1'b1;
          r.frame_end     = 1'b0;
          r.leftover_bits = '0;
          awaited.push_back(r);
        end
      end
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: data_byte %0h byte_valid %0b frame_end %0b",
               got.data_byte, got.byte_valid, got.frame_end);
        errors++;
        return;
      end
      exp_r = awaited.pop_front();
      if (got.data_byte !== exp_r.data_byte) begin
        $error("data_byte: expected %0h, actual %0h", exp_r.data_byte, got.data_byte);
        errors++;
      end
      if (got.byte_valid !== exp_r.byte_valid) begin
        $error("byte_valid: expected %0b, actual %0b", exp_r.byte_valid, got.byte_valid);
        errors++;
      end
      if (got.frame_end !== exp_r.frame_end) begin
        $error("frame_end: expected %0b, actual %0b", exp_r.frame_end, got.frame_end);
        errors++;
      end
      if (got.leftover_bits !== exp_r.leftover_bits) begin
        $error("leftover_bits: expected %0d, actual %0d", exp_r.leftover_bits,
               got.leftover_bits);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [6:0] septet = '0;
  logic       last_septet = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       frame_end;
  logic [2:0] leftover_bits;

  unpack_scoreboard sb = new();

  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  logic hold_req      = 1'b0;
  int   hold_left     = 0;
  int   cycles        = 0;
  int   sent          = 0;

  septet_stream_to_byte_unpack_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .septet       (septet),
    .last_septet  (last_septet),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_byte    (data_byte),
    .byte_valid   (byte_valid),
    .frame_end    (frame_end),
    .leftover_bits(leftover_bits)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_septet_stream_to_byte_unpack_top NOT OK");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_LEN;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_septet(septet, last_septet);
    if (!rst && out_valid && !out_stall)
      sb.check_result({data_byte, byte_valid, frame_end, leftover_bits});
  end

  task automatic send_septet(input logic [6:0] s, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    septet      <= s;
    last_septet <= last;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // The scoreboard is read away from the rising edge, after the last transfer is noted.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_frame(input int len, input int fill_mode);
    logic [6:0] s;
    for (int i = 0; i < len; i++) begin
      case (fill_mode)
        0: s = 7'h00;
        1: s = 7'h7f;
        default: s = 7'($urandom());
      endcase
      send_septet(s, i == len - 1);
    end
  endtask

  initial begin
    int len;
    int mode;
    int target;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One-septet frames: no byte, seven bits dropped.
    send_septet(7'h7f, 1'b1);
    send_septet(7'h00, 1'b1);
    // Eight all-ones septets: the last one completes a byte with nothing left over.
    send_frame(8, 1);
    // First septet completes nothing; the second completes a byte, six bits dropped.
    send_septet(7'h40, 1'b0);
    send_septet(7'h01, 1'b1);
    // Alternating patterns across a frame longer than one full cycle of alignments.
    for (int i = 0; i < 9; i++)
      send_septet((i % 2) ? 7'h2a : 7'h55, i == 8);
    send_septet(7'h40, 1'b0);
    send_septet(7'h01, 1'b0);
    send_septet(7'h7f, 1'b1);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 80; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 80; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      // The receiver holds off while the sender keeps offering, so the block backs up.
      if (phase == 0) hold_req = 1'b1;
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
        len  = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(1, 12);
        mode = ($urandom_range(15) == 0) ? $urandom_range(1) : 2;
        if (phase == 3 && $urandom_range(9) == 0) begin
          // Sender pauses after a short frame until every awaited result is out.
          send_frame(3, 2);
          wait_drained();
        end
        if (phase == 1 && len > 4 && $urandom_range(7) == 0) begin
          for (int i = 0; i < len; i++) begin
            send_septet(7'($urandom()), i == len - 1);
            if (i == len / 2) wait_drained();
          end
        end else begin
          send_frame(len, mode);
        end
      end
      wait_drained();
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_septet_stream_to_byte_unpack_top OK");
    end else begin
      $display("tb_septet_stream_to_byte_unpack_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/spu_pkg.sv
src/spu_in_stage.sv
src/spu_unpack.sv
src/septet_stream_to_byte_unpack_top.sv
test/tb_septet_stream_to_byte_unpack_top.sv
